@@ hw/rtl/glpt_pkg.sv @@
package glpt_pkg;

    // Intensity resolution of the log curve table; the table keeps
    // INTENSITY_BITS-8 fraction bits.
    localparam int INTENSITY_BITS = 8;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 10;
    localparam int GRAY_W      = 8;
    localparam int LEVEL_W     = 8;
    localparam int MODE_W      = 3;
    localparam int KNEE_W      = 8;
    localparam int GAIN_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // floor(x/3) == (x*683) >> 11 for every x below 2048.
    localparam int RECIP_W     = 10;
    localparam int RECIP_3     = 683;
    localparam int RECIP_SHIFT = 11;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_GRAY      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STRETCH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOG       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NEGATIVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_IN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_IN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_OUT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_OUT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_GAIN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd6;

    // Log curve arithmetic.
    localparam int LOG_FRAC    = INTENSITY_BITS - 8;
    localparam int LOG_SHIFT   = 12 + LOG_FRAC;
    localparam int LOG_ENTRY_W = INTENSITY_BITS;
    localparam int LOG_PROD_W  = GAIN_W + LOG_ENTRY_W;
    localparam int LOG_RND_W   = LOG_PROD_W + 1 - LOG_SHIFT;
    localparam int LOG_DEPTH   = 1 << GRAY_W;

    localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Stretch divider: numerator 2t+den, divisor 2*den, eight quotient bits.
    localparam int NUM_W              = 17;
    localparam int DEN_W              = 9;
    localparam int QUO_W              = 8;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KNEE_W-1:0] low_in;
        logic [KNEE_W-1:0] high_in;
        logic [KNEE_W-1:0] low_out;
        logic [KNEE_W-1:0] high_out;
        logic [GAIN_W-1:0] log_gain;
        logic [KNEE_W-1:0] threshold_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:            MODE_GRAY,
        low_in:          8'd0,
        high_in:         8'd255,
        low_out:         8'd0,
        high_out:        8'd255,
        log_gain:        16'd4096,
        threshold_level: 8'd128
    };

    typedef struct packed {
        logic                   log_sel;
        logic                   use_div;
        logic [LEVEL_W-1:0]     direct;
        logic [NUM_W-1:0]       num;
        logic [DEN_W-1:0]       den;
        logic [LOG_ENTRY_W-1:0] log_entry;
    } t_map;

    typedef struct packed {
        logic               use_div;
        logic [LEVEL_W-1:0] direct;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_in;

    typedef struct packed {
        logic               use_div;
        logic [LEVEL_W-1:0] direct;
        logic [QUO_W-1:0]   quotient;
    } t_div_out;

    typedef logic [LOG_DEPTH-1:0][LOG_ENTRY_W-1:0] t_log_table;

    // 255*log10(1+g/255) per gray level, via a squaring log2 in Q24.
    function automatic t_log_table build_log_table();
        t_log_table  tab;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] l10;
        logic [63:0] v;
        tab = '0;
        for (int g = 0; g < LOG_DEPTH; g++) begin
            x = ((64'd255 + 64'(g)) << 30) / 64'd255;
            r = '0;
            if (x >= 2 * ONE_Q30) begin
                r = 64'd1 << 24;
                x = x >> 1;
            end
            for (int i = 23; i >= 0; i--) begin
                x = (x * x) >> 30;
                if (x >= 2 * ONE_Q30) begin
                    x = x >> 1;
                    r = r | (64'd1 << i);
                end
            end
            l10 = (r * LOG10_2_Q32) >> 32;
            v = (64'd255 * l10) << LOG_FRAC;
            tab[g] = LOG_ENTRY_W'((v + (64'd1 << 23)) >> 24);
        end
        return tab;
    endfunction

    localparam t_log_table LOG_TABLE = build_log_table();

endpackage

@@ hw/rtl/glpt_gray.sv @@
module glpt_gray (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [glpt_pkg::PIX_W-1:0] i_red,
    input  logic [glpt_pkg::PIX_W-1:0] i_green,
    input  logic [glpt_pkg::PIX_W-1:0] i_blue,
    output logic                       o_valid,
    output logic [glpt_pkg::GRAY_W-1:0] o_gray
);
    import glpt_pkg::*;

    logic                         r_vld1;
    logic                         r_vld2;
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             n_sum;
    logic [GRAY_W-1:0]            r_gray;
    logic [GRAY_W-1:0]            n_gray;
    logic [SUM_W+RECIP_W-1:0]     w_prod;

    // The +1 makes the truncating divide by three round to nearest.
    assign n_sum  = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue) + SUM_W'(1);
    assign w_prod = (SUM_W+RECIP_W)'(r_sum) * (SUM_W+RECIP_W)'(RECIP_3);
    assign n_gray = w_prod[RECIP_SHIFT +: GRAY_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_gray <= n_gray;
        end
    end

    assign o_valid = r_vld2;
    assign o_gray  = r_gray;

`ifndef SYNTHESIS
    a_gray_is_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> ((SUM_W'(n_gray) * SUM_W'(3) <= r_sum) &&
                    (r_sum < SUM_W'(n_gray) * SUM_W'(3) + SUM_W'(3))))
        else $error("gray level is not the floor of sum/3");
`endif

endmodule

@@ hw/rtl/glpt_map.sv @@
module glpt_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [glpt_pkg::GRAY_W-1:0] i_gray,
    input  glpt_pkg::t_cfg              i_cfg,
    output logic                        o_valid,
    output glpt_pkg::t_map              o_map
);
    import glpt_pkg::*;

    logic              r_vld;
    t_map              r_map;
    t_map              n_map;
    logic              w_above;
    logic              w_below;
    logic [KNEE_W-1:0] w_den;
    logic [15:0]       w_prod_lo;
    logic [15:0]       w_prod_hi;
    logic [15:0]       w_t;

    assign w_above   = i_gray > i_cfg.high_in;
    assign w_below   = i_gray < i_cfg.low_in;
    assign w_den     = i_cfg.high_in - i_cfg.low_in;
    // Only meaningful inside the middle segment, where t <= 255*den.
    assign w_prod_lo = 16'(i_cfg.low_out) * 16'(KNEE_W'(i_cfg.high_in - i_gray));
    assign w_prod_hi = 16'(i_cfg.high_out) * 16'(KNEE_W'(i_gray - i_cfg.low_in));
    assign w_t       = w_prod_lo + w_prod_hi;

    always_comb begin
        n_map           = '0;
        n_map.log_sel   = (i_cfg.mode == MODE_LOG);
        n_map.use_div   = (i_cfg.mode == MODE_STRETCH) && !w_above && !w_below &&
                          (i_cfg.high_in != i_cfg.low_in);
        n_map.num       = {w_t, 1'b0} + NUM_W'(w_den);
        n_map.den       = {w_den, 1'b0};
        n_map.log_entry = LOG_TABLE[i_gray];
        unique case (i_cfg.mode)
            MODE_STRETCH:   n_map.direct = w_above ? i_cfg.high_out : i_cfg.low_out;
            MODE_LOG:       n_map.direct = '0;
            MODE_NEGATIVE:  n_map.direct = LEVEL_MAX - i_gray;
            MODE_THRESHOLD: n_map.direct = (i_gray > i_cfg.threshold_level) ?
                                           LEVEL_MAX : '0;
            default:        n_map.direct = i_gray;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_map <= n_map;
        end
    end

    assign o_valid = r_vld;
    assign o_map   = r_map;

endmodule

@@ hw/rtl/glpt_log.sv @@
module glpt_log (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  glpt_pkg::t_map              i_map,
    input  logic [glpt_pkg::GAIN_W-1:0] i_gain,
    output logic                        o_valid,
    output glpt_pkg::t_div_in           o_div
);
    import glpt_pkg::*;

    logic                  r_vld_a;
    logic                  r_vld_b;
    logic                  r_log_sel;
    t_div_in               r_pass;
    logic [LOG_PROD_W-1:0] r_prod;
    t_div_in               r_div;
    t_div_in               n_div;
    logic [LOG_PROD_W:0]   w_sum;
    logic [LOG_RND_W-1:0]  w_rnd;
    logic [LEVEL_W-1:0]    w_level;

    assign w_sum   = {1'b0, r_prod} + ((LOG_PROD_W+1)'(1) << (LOG_SHIFT - 1));
    assign w_rnd   = w_sum[LOG_PROD_W:LOG_SHIFT];
    assign w_level = (w_rnd > LOG_RND_W'(LEVEL_MAX)) ? LEVEL_MAX : w_rnd[LEVEL_W-1:0];

    always_comb begin
        n_div = r_pass;
        if (r_log_sel) begin
            n_div.direct = w_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod         <= LOG_PROD_W'(i_gain) * LOG_PROD_W'(i_map.log_entry);
            r_log_sel      <= i_map.log_sel;
            r_pass.use_div <= i_map.use_div;
            r_pass.direct  <= i_map.direct;
            r_pass.num     <= i_map.num;
            r_pass.den     <= i_map.den;
            r_div          <= n_div;
        end
    end

    assign o_valid = r_vld_b;
    assign o_div   = r_div;

endmodule

@@ hw/rtl/glpt_divider.sv @@
module glpt_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  glpt_pkg::t_div_in  i_div,
    output logic               o_valid,
    output glpt_pkg::t_div_out o_div
);
    import glpt_pkg::*;

    typedef struct packed {
        logic               use_div;
        logic [LEVEL_W-1:0] direct;
        logic [NUM_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [QUO_W-1:0]   quo;
    } t_div_step;

    logic      r_vld  [DIV_STAGES];
    t_div_step r_step [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int BASE = QUO_W - 1 - s * DIV_BITS_PER_STAGE;

        logic      w_vld_in;
        t_div_step w_in;
        t_div_step w_out;

        if (s == 0) begin : g_first
            assign w_vld_in     = i_valid;
            assign w_in.use_div = i_div.use_div;
            assign w_in.direct  = i_div.direct;
            assign w_in.rem     = i_div.num;
            assign w_in.den     = i_div.den;
            assign w_in.quo     = '0;
        end else begin : g_next
            assign w_vld_in = r_vld[s-1];
            assign w_in     = r_step[s-1];
        end

        // Restoring division, two quotient bits from the top down.
        always_comb begin
            w_out = w_in;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                if (w_out.rem >= (NUM_W'(w_out.den) << (BASE - b))) begin
                    w_out.rem = w_out.rem - (NUM_W'(w_out.den) << (BASE - b));
                    w_out.quo = w_out.quo | (QUO_W'(1) << (BASE - b));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_step[s] <= w_out;
            end
        end
    end

    assign o_valid        = r_vld[DIV_STAGES-1];
    assign o_div.use_div  = r_step[DIV_STAGES-1].use_div;
    assign o_div.direct   = r_step[DIV_STAGES-1].direct;
    assign o_div.quotient = r_step[DIV_STAGES-1].quo;

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_STAGES-1] && r_step[DIV_STAGES-1].use_div) |->
        (r_step[DIV_STAGES-1].rem < NUM_W'(r_step[DIV_STAGES-1].den)))
        else $error("divider remainder not below divisor");
`endif

endmodule

@@ hw/rtl/gray_level_point_transform.sv @@
// Gray-level point transform: one RGB pixel in, one 8-bit level out.
// Pixel channel: i_valid with i_red/i_green/i_blue; the block drives o_stall.
// A request is taken at a clock edge where i_valid is high and o_stall low.
// Result channel: o_valid with o_level; the receiver drives i_stall, and a
// result is taken at an edge where o_valid is high and i_stall low.
// Configuration: i_cfg_valid, i_cfg_index, i_cfg_data; o_cfg_ready is
// always high. Index 0 mode, 1 low_in, 2 high_in, 3 low_out, 4 high_out,
// 5 log_gain, 6 threshold_level; index 7 is ignored. Write only while idle.
// The pipeline has ten register stages: rounded mean (2), mode mapping
// (1), log gain multiply and clamp (2), stretch divider with two quotient
// bits per stage (4), output (1). The accepting edge loads the first stage.
// Throughput is one pixel per clock while i_stall does not hold the pipeline.
// While o_valid is high and i_stall is high the whole pipeline holds,
// o_stall is raised and o_level stays unchanged; nothing is dropped.
// Synchronous reset empties the pipeline and loads the register defaults:
// gray pass-through, knees 0/255, levels 0/255, gain 1.0, threshold 128.
module gray_level_point_transform (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [glpt_pkg::PIX_W-1:0]      i_red,
    input  logic [glpt_pkg::PIX_W-1:0]      i_green,
    input  logic [glpt_pkg::PIX_W-1:0]      i_blue,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [glpt_pkg::LEVEL_W-1:0]    o_level,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [glpt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [glpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import glpt_pkg::*;

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic               w_en;
    logic               w_gray_vld;
    logic [GRAY_W-1:0]  w_gray;
    logic               w_map_vld;
    t_map               w_map;
    logic               w_log_vld;
    t_div_in            w_log;
    logic               w_div_vld;
    t_div_out           w_div;
    logic               r_out_vld;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [KNEE_W-1:0]  w_lvl_min;
    logic [KNEE_W-1:0]  w_lvl_max;

    // The pipeline advances as a whole unless a finished result is refused.
    assign w_en        = !(r_out_vld && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:      n_cfg.mode            = i_cfg_data[MODE_W-1:0];
                CFG_LOW_IN:    n_cfg.low_in          = i_cfg_data[KNEE_W-1:0];
                CFG_HIGH_IN:   n_cfg.high_in         = i_cfg_data[KNEE_W-1:0];
                CFG_LOW_OUT:   n_cfg.low_out         = i_cfg_data[KNEE_W-1:0];
                CFG_HIGH_OUT:  n_cfg.high_out        = i_cfg_data[KNEE_W-1:0];
                CFG_LOG_GAIN:  n_cfg.log_gain        = i_cfg_data[GAIN_W-1:0];
                CFG_THRESHOLD: n_cfg.threshold_level = i_cfg_data[KNEE_W-1:0];
                default:       n_cfg                 = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    glpt_gray u_gray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_gray_vld),
        .o_gray  (w_gray)
    );

    glpt_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_gray_vld),
        .i_gray  (w_gray),
        .i_cfg   (r_cfg),
        .o_valid (w_map_vld),
        .o_map   (w_map)
    );

    glpt_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_map_vld),
        .i_map   (w_map),
        .i_gain  (r_cfg.log_gain),
        .o_valid (w_log_vld),
        .o_div   (w_log)
    );

    glpt_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_log_vld),
        .i_div   (w_log),
        .o_valid (w_div_vld),
        .o_div   (w_div)
    );

    assign n_level = w_div.use_div ? w_div.quotient : w_div.direct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_level <= n_level;
        end
    end

    assign o_valid = r_out_vld;
    assign o_level = r_level;

    assign w_lvl_min = (r_cfg.low_out < r_cfg.high_out) ? r_cfg.low_out : r_cfg.high_out;
    assign w_lvl_max = (r_cfg.low_out < r_cfg.high_out) ? r_cfg.high_out : r_cfg.low_out;

`ifndef SYNTHESIS
    a_threshold_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_cfg.mode == MODE_THRESHOLD)) |->
        ((o_level == '0) || (o_level == LEVEL_MAX)))
        else $error("threshold result is neither black nor white");

    a_stretch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_vld && w_div.use_div) |->
        ((w_div.quotient >= w_lvl_min) && (w_div.quotient <= w_lvl_max)))
        else $error("stretch result outside the output levels");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_vld && i_stall))
        else $error("pipeline held without a refused result");
`endif

endmodule
